// ----- hw/rtl/mif_text_stream_parser_assert.svh -----
// Assertion macros for the MIF text stream parser.
`ifndef MIF_TEXT_STREAM_PARSER_ASSERT_SVH
`define MIF_TEXT_STREAM_PARSER_ASSERT_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define MTSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the following cycle.
`define MTSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mtsp_pkg.sv -----
// ----------------------------------------------------------------------------
// mtsp_pkg
// Types and constants shared by the MIF text stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mtsp_pkg;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BLOCK = 2'd1,
    KIND_EOF   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  localparam logic [3:0] ERR_HEADER    = 4'd0;
  localparam logic [3:0] ERR_EQUALS    = 4'd1;
  localparam logic [3:0] ERR_NUMBER    = 4'd2;
  localparam logic [3:0] ERR_SEMICOLON = 4'd3;
  localparam logic [3:0] ERR_COLON     = 4'd4;
  localparam logic [3:0] ERR_RADIX     = 4'd5;
  localparam logic [3:0] ERR_WIDTH     = 4'd6;
  localparam logic [3:0] ERR_BEGIN     = 4'd7;
  localparam logic [3:0] ERR_ADDRESS   = 4'd8;
  localparam logic [3:0] ERR_DATA      = 4'd9;

  localparam logic [63:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] byte_address;
    logic [63:0] word_value;
    logic [3:0]  word_bytes;
    logic        record_last;
    logic [3:0]  error_code;
  } result_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } item_t;

endpackage

// ----- hw/rtl/mtsp_if.sv -----
// ----------------------------------------------------------------------------
// mtsp_if
// Valid/ready channel carrying one payload transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mtsp_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/mif_text_stream_parser.sv -----
// ----------------------------------------------------------------------------
// mif_text_stream_parser
// Character-serial parser for memory-initialization file text.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_ch     in   {char_code[7:0], end_of_input}
// out_ch    out  result_t {kind, byte_address, word_value, word_bytes,
//                          record_last, error_code}
//
// One character per cycle; the lexer, keyword match and shift-add run in a
// single combinational pass between the character and the result queue.
// A character yields at most two results, held in a four-entry queue.
// Input stalls only while the queue lacks room for two more results.
// Reset clears the parser to its header state and empties the queue.
`timescale 1ns / 1ps
module mif_text_stream_parser #(
  parameter int RECORD_BYTES = 256
) (
  input logic  clk_i,
  input logic  rst_ni,
  mtsp_if.sink   in_ch,
  mtsp_if.source out_ch
);
  import mtsp_pkg::*;
`include "mif_text_stream_parser_assert.svh"

  item_t      item;
  result_t    r0, r1, head;
  logic [1:0] n;
  logic [2:0] cnt;
  logic       step, halted;

  // Accept while two slots are free.
  assign in_ch.ready = cnt <= 3'd2;
  assign step = in_ch.valid && in_ch.ready;
  assign item = in_ch.data;

  mtsp_core #(.RECORD_BYTES(RECORD_BYTES)) u_core (
    .clk_i, .rst_ni, .step_i(step), .item_i(item),
    .res_n_o(n), .res0_o(r0), .res1_o(r1), .halted_o(halted)
  );

  mtsp_out_buf u_buf (
    .clk_i, .rst_ni, .wr_n_i(n), .wr0_i(r0), .wr1_i(r1),
    .count_o(cnt), .valid_o(out_ch.valid), .ready_i(out_ch.ready), .data_o(head)
  );

  assign out_ch.data = head;

  `MTSP_ASSERT_IMPL(a_no_res_idle, clk_i, rst_ni, !step, n == 2'd0,
                    "result without accepted character")
  `MTSP_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt <= 3'd4, "queue overflow")
  `MTSP_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted, halted, "halt released")
  `MTSP_ASSERT_IMPL(a_halt_quiet, clk_i, rst_ni, halted, n == 2'd0,
                    "result after halt")
endmodule

// ----- hw/rtl/mtsp_core.sv -----
// ----------------------------------------------------------------------------
// mtsp_core
// Lexer, keyword matcher, number accumulator and parser for one character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mtsp_core #(
  parameter int RECORD_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  mtsp_pkg::item_t   item_i,
  output logic [1:0]        res_n_o,
  output mtsp_pkg::result_t res0_o,
  output mtsp_pkg::result_t res1_o,
  output logic              halted_o
);
  import mtsp_pkg::*;

  localparam int FW = $clog2(RECORD_BYTES + 17);

  typedef enum logic [4:0] {
    LX_BETWEEN = 5'b00001,
    LX_PERCENT = 5'b00010,
    LX_MINUS   = 5'b00100,
    LX_DASHCOM = 5'b01000,
    LX_IDENT   = 5'b10000
  } lex_e;

  // Token codes
  localparam logic [4:0] TK_EQ = 5'd0, TK_COLON = 5'd1, TK_SEMI = 5'd2, TK_MINUS = 5'd3,
    TK_JUNK = 5'd4, TK_EOF = 5'd5, TK_NUM = 5'd6, TK_ADDR = 5'd7, TK_BEGIN = 5'd8,
    TK_BIN = 5'd9, TK_CONTENT = 5'd10, TK_DRADIX = 5'd11, TK_DEC = 5'd12,
    TK_DEPTH = 5'd13, TK_END = 5'd14, TK_HEX = 5'd15, TK_OCT = 5'd16, TK_WIDTH = 5'd17;
  localparam logic [1:0] PH_HEADER = 2'd0, PH_ADDRESS = 2'd1, PH_DATA = 2'd2,
    PH_DONE = 2'd3;
  localparam logic [1:0] RX_BIN = 2'd0, RX_OCT = 2'd1, RX_DEC = 2'd2, RX_HEX = 2'd3;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  hstep_q, hstep_d;
  logic [1:0]  hitem_q, hitem_d;
  lex_e        lex_q, lex_d;
  logic [11:0] cand_q, cand_d;
  logic [4:0]  tlen_q, tlen_d;
  logic [63:0] acc_q, acc_d;
  logic        dval_q, dval_d;
  logic [6:0]  width_q, width_d;
  logic [1:0]  arad_q, arad_d, drad_q, drad_d;
  logic [31:0] addr_q, addr_d;
  logic [FW-1:0] fill_q, fill_d;
  logic        halt_q, halt_d;

  function automatic logic [7:0] kw_char(input int k, input logic [4:0] i);
    logic [103:0] s;
    case (k)
      0: s = {"ADDRESS", "_RADIX"};
      1: s = {"BEGIN", 64'd0};
      2: s = {"BIN", 80'd0};
      3: s = {"CONTENT", 48'd0};
      4: s = {"DATA", "_RADIX", 24'd0};
      5: s = {"DEC", 80'd0};
      6: s = {"DEPTH", 64'd0};
      7: s = {"END", 80'd0};
      8: s = {"HEX", 80'd0};
      9: s = {"OCT", 80'd0};
      10: s = {"UNS", 80'd0};
      default: s = {"WIDTH", 64'd0};
    endcase
    if (i > 5'd12) kw_char = 8'd0;
    else kw_char = s[103 - 8*i -: 8];
  endfunction

  function automatic logic [4:0] kw_len(input int k);
    case (k)
      0: kw_len = 5'd13;
      1, 6, 11: kw_len = 5'd5;
      3: kw_len = 5'd7;
      4: kw_len = 5'd10;
      default: kw_len = 5'd3;
    endcase
  endfunction

  function automatic logic [4:0] kw_tok(input int k);
    case (k)
      0: kw_tok = TK_ADDR;
      1: kw_tok = TK_BEGIN;
      2: kw_tok = TK_BIN;
      3: kw_tok = TK_CONTENT;
      4: kw_tok = TK_DRADIX;
      5, 10: kw_tok = TK_DEC;
      6: kw_tok = TK_DEPTH;
      7: kw_tok = TK_END;
      8: kw_tok = TK_HEX;
      9: kw_tok = TK_OCT;
      default: kw_tok = TK_WIDTH;
    endcase
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    is_ident = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               (c >= "0" && c <= "9") || c == "_";
  endfunction

  // Take one token: update parser state and emit into the result slots.
  function automatic void take(
    input  logic [4:0] tok, input logic [63:0] val,
    inout  logic [1:0] ph, inout logic [2:0] hs, inout logic [1:0] hi,
    inout  logic [6:0] wd, inout logic [1:0] ar, inout logic [1:0] dr,
    inout  logic [31:0] ad, inout logic [FW-1:0] fl, inout logic hl,
    inout  logic [1:0] n, inout result_t r0, inout result_t r1);
    result_t r;
    logic    em;
    logic [3:0] nb;
    logic [FW-1:0] nf;
    logic [63:0] mask;
    r = '0;
    em = 1'b0;
    nb = 4'((wd + 7'd7) >> 3);
    mask = (nb >= 4'd8) ? '1 : ((64'd1 << {nb, 3'b000}) - 64'd1);
    case (ph)
      PH_HEADER: begin
        case (hs)
          3'd1: if (tok == TK_EQ) hs = 3'd2;
                else begin em = 1'b1; r.error_code = ERR_EQUALS; end
          3'd2: begin
            if (hi <= 2'd1) begin
              if (tok != TK_NUM) begin em = 1'b1; r.error_code = ERR_NUMBER; end
              else if (hi == 2'd1 && (val < 64'd1 || val > 64'd64)) begin
                em = 1'b1; r.error_code = ERR_WIDTH;
              end else begin
                if (hi == 2'd1) wd = val[6:0];
                hs = 3'd3;
              end
            end else begin
              logic [1:0] rs;
              logic ok;
              ok = 1'b1;
              rs = RX_DEC;
              if (tok == TK_HEX) rs = RX_HEX;
              else if (tok == TK_OCT) rs = RX_OCT;
              else if (tok == TK_BIN) rs = RX_BIN;
              else if (tok != TK_DEC) ok = 1'b0;
              if (!ok) begin em = 1'b1; r.error_code = ERR_RADIX; end
              else begin
                if (hi == 2'd2) ar = rs; else dr = rs;
                hs = 3'd3;
              end
            end
          end
          3'd3: if (tok == TK_SEMI) hs = 3'd0;
                else begin em = 1'b1; r.error_code = ERR_SEMICOLON; end
          3'd4: if (tok == TK_BEGIN) begin ph = PH_ADDRESS; hs = 3'd0; end
                else begin em = 1'b1; r.error_code = ERR_BEGIN; end
          default: begin
            hs = 3'd1;
            if (tok == TK_DEPTH) hi = 2'd0;
            else if (tok == TK_WIDTH) hi = 2'd1;
            else if (tok == TK_ADDR) hi = 2'd2;
            else if (tok == TK_DRADIX) hi = 2'd3;
            else if (tok == TK_CONTENT) hs = 3'd4;
            else begin em = 1'b1; r.error_code = ERR_HEADER; end
          end
        endcase
        if (em) begin r.result_kind = KIND_ERROR; hl = 1'b1; ph = PH_DONE; end
      end
      PH_ADDRESS: begin
        if (hs == 3'd0) begin
          if (tok == TK_NUM) begin
            ad = val[31:0] * {28'd0, nb};
            hs = 3'd1;
          end else if (tok == TK_END) begin
            em = 1'b1; r.result_kind = KIND_EOF; hl = 1'b1; ph = PH_DONE;
          end else begin
            em = 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_ADDRESS;
            hl = 1'b1; ph = PH_DONE;
          end
        end else if (tok == TK_COLON) begin
          ph = PH_DATA; hs = 3'd0;
        end else begin
          em = 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_COLON;
          hl = 1'b1; ph = PH_DONE;
        end
      end
      PH_DATA: begin
        if (tok == TK_NUM) begin
          em = 1'b1;
          r.result_kind = KIND_DATA;
          r.byte_address = ad;
          r.word_value = val & mask;
          r.word_bytes = nb;
          ad = ad + {28'd0, nb};
          nf = fl + FW'(nb);
          if (nf + FW'(nb) > FW'(RECORD_BYTES)) begin r.record_last = 1'b1; nf = '0; end
          fl = nf;
        end else if (tok == TK_SEMI) begin
          ph = PH_ADDRESS; hs = 3'd0;
          if (fl != '0) begin fl = '0; em = 1'b1; r.result_kind = KIND_BLOCK; end
        end else begin
          em = 1'b1; r.result_kind = KIND_ERROR; r.error_code = ERR_DATA;
          hl = 1'b1; ph = PH_DONE;
        end
      end
      default: ;
    endcase
    if (em) begin
      if (n == 2'd0) r0 = r;
      else if (n == 2'd1) r1 = r;
      if (n != 2'd2) n = n + 2'd1;
    end
  endfunction

  always_comb begin
    logic [7:0]  c;
    logic [4:0]  ktok;
    logic        kfound;
    logic        fin;
    logic        do_take;
    logic [4:0]  rad;
    logic [4:0]  dg;
    logic [63:0] lim;
    logic [68:0] prod;
    logic        absorb;
    logic        start;
    phase_d = phase_q; hstep_d = hstep_q; hitem_d = hitem_q; lex_d = lex_q;
    cand_d = cand_q; tlen_d = tlen_q; acc_d = acc_q; dval_d = dval_q;
    width_d = width_q; arad_d = arad_q; drad_d = drad_q; addr_d = addr_q;
    fill_d = fill_q; halt_d = halt_q;
    res_n_o = 2'd0; res0_o = '0; res1_o = '0;
    rad = 5'd10; dg = 5'd0; prod = '0; lim = NUM_MAX;
    c = item_i.char_code;
    ktok = TK_JUNK; kfound = 1'b0;
    for (int k = 11; k >= 0; k--) begin
      if (cand_q[k] && tlen_q == kw_len(k)) begin kfound = 1'b1; ktok = kw_tok(k); end
    end
    fin = 1'b0; absorb = 1'b0; start = 1'b0; do_take = 1'b0;
    if (step_i && !halt_q) begin
      // Close any pending token first.
      if (lex_q == LX_IDENT && (item_i.end_of_input || !is_ident(c))) fin = 1'b1;
      if (fin) begin
        lex_d = LX_BETWEEN;
        if (kfound) take(ktok, 64'd0, phase_d, hstep_d, hitem_d, width_d, arad_d,
                         drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
        else if (dval_q && tlen_q != 5'd0)
          take(TK_NUM, acc_q, phase_d, hstep_d, hitem_d, width_d, arad_d, drad_d,
               addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
        else take(TK_JUNK, 64'd0, phase_d, hstep_d, hitem_d, width_d, arad_d,
                  drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
      end
      if (item_i.end_of_input) begin
        if (lex_q == LX_MINUS)
          take(TK_MINUS, 64'd0, phase_d, hstep_d, hitem_d, width_d, arad_d, drad_d,
               addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
        lex_d = LX_BETWEEN;
        if (!halt_d) take(TK_EOF, 64'd0, phase_d, hstep_d, hitem_d, width_d, arad_d,
                          drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
      end else begin
        case (lex_q)
          LX_PERCENT: if (c == "%") lex_d = LX_BETWEEN;
          LX_DASHCOM: if (c == 8'h0A) lex_d = LX_BETWEEN;
          LX_MINUS: begin
            if (c == "-") lex_d = LX_DASHCOM;
            else begin
              lex_d = LX_BETWEEN;
              take(TK_MINUS, 64'd0, phase_d, hstep_d, hitem_d, width_d, arad_d,
                   drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
              do_take = 1'b1;
            end
          end
          LX_IDENT: if (!fin) absorb = 1'b1; else do_take = 1'b1;
          default: begin lex_d = LX_BETWEEN; do_take = 1'b1; end
        endcase
        if (do_take && !halt_d) begin
          if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) ;
          else if (c == "=") take(TK_EQ, 64'd0, phase_d, hstep_d, hitem_d, width_d,
                   arad_d, drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
          else if (c == ":") take(TK_COLON, 64'd0, phase_d, hstep_d, hitem_d, width_d,
                   arad_d, drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
          else if (c == ";") take(TK_SEMI, 64'd0, phase_d, hstep_d, hitem_d, width_d,
                   arad_d, drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
          else if (c == "%") lex_d = LX_PERCENT;
          else if (c == "-") lex_d = LX_MINUS;
          else if (is_ident(c)) begin
            lex_d = LX_IDENT; start = 1'b1; absorb = 1'b1;
          end else take(TK_JUNK, 64'd0, phase_d, hstep_d, hitem_d, width_d, arad_d,
                        drad_d, addr_d, fill_d, halt_d, res_n_o, res0_o, res1_o);
        end
      end
      if (absorb) begin
        // Radix follows the phase after any token taken on this character.
        logic [1:0]  rsel;
        logic [11:0] cb;
        logic [4:0]  tl;
        logic [63:0] ab;
        logic        vb;
        cb = start ? 12'hFFF : cand_q;
        tl = start ? 5'd0 : tlen_q;
        ab = start ? 64'd0 : acc_q;
        vb = start ? 1'b1 : dval_q;
        if (phase_d == PH_ADDRESS && hstep_d == 3'd0) rsel = arad_d;
        else if (phase_d == PH_DATA) rsel = drad_d;
        else rsel = RX_DEC;
        // Scale by the radix with shifts, and one add for decimal.
        case (rsel)
          RX_BIN: begin rad = 5'd2; prod = {5'd0, ab} << 1; end
          RX_OCT: begin rad = 5'd8; prod = {5'd0, ab} << 3; end
          RX_HEX: begin rad = 5'd16; prod = {5'd0, ab} << 4; end
          default: begin
            rad = 5'd10;
            prod = ({5'd0, ab} << 3) + ({5'd0, ab} << 1);
          end
        endcase
        for (int k = 0; k < 12; k++)
          if (tl >= kw_len(k) || kw_char(k, tl) != c) cb[k] = 1'b0;
        cand_d = cb;
        tlen_d = (tl < 5'd31) ? tl + 5'd1 : tl;
        if (c >= "0" && c <= "9") dg = 5'(c - "0");
        else if (c >= "a" && c <= "f") dg = 5'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") dg = 5'(c - "A" + 8'd10);
        else dg = 5'd31;
        prod = prod + {64'd0, dg};
        if (dg >= rad) dval_d = 1'b0;
        else begin
          dval_d = vb;
          acc_d = (prod > {5'd0, lim}) ? NUM_MAX : prod[63:0];
        end
        if (dg >= rad) acc_d = ab;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hstep_q <= '0; hitem_q <= '0; lex_q <= LX_BETWEEN;
      cand_q <= 12'hFFF; tlen_q <= '0; acc_q <= '0; dval_q <= 1'b1;
      width_q <= 7'd8; arad_q <= RX_HEX; drad_q <= RX_HEX; addr_q <= '0;
      fill_q <= '0; halt_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hstep_q <= hstep_d; hitem_q <= hitem_d; lex_q <= lex_d;
      cand_q <= cand_d; tlen_q <= tlen_d; acc_q <= acc_d; dval_q <= dval_d;
      width_q <= width_d; arad_q <= arad_d; drad_q <= drad_d; addr_q <= addr_d;
      fill_q <= fill_d; halt_q <= halt_d;
    end
  end

  assign halted_o = halt_q;
endmodule

// ----- hw/rtl/mtsp_out_buf.sv -----
// ----------------------------------------------------------------------------
// mtsp_out_buf
// Four-slot result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mtsp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        wr_n_i,
  input  mtsp_pkg::result_t wr0_i,
  input  mtsp_pkg::result_t wr1_i,
  output logic [2:0]        count_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mtsp_pkg::result_t data_o
);
  import mtsp_pkg::*;

  result_t    slot_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 3'd0;
  assign pop     = valid_o && ready_i;
  assign data_o  = slot_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_n_i != 2'd0) slot_q[wr_q] <= wr0_i;
    if (wr_n_i == 2'd2) slot_q[wr_q + 2'd1] <= wr1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + wr_n_i;
      if (pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, wr_n_i} - {2'b0, pop};
    end
  end
endmodule
